### hdl/dual_motor_voltage_to_pwm_core_defines.svh
// ----------------------------------------------------------------------------
// Dual motor voltage to PWM core - assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_VOLTAGE_TO_PWM_CORE_DEFINES_SVH
`define DUAL_MOTOR_VOLTAGE_TO_PWM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define DMVP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dmvp assertion failed");
// same-cycle implication
`define DMVP_ASSERT_IMP(lbl, ante, cons) \
	`DMVP_ASSERT(lbl, (ante) |-> (cons))
// next-cycle implication
`define DMVP_ASSERT_NEXT(lbl, ante, cons) \
	`DMVP_ASSERT(lbl, (ante) |=> (cons))
`else
`define DMVP_ASSERT(lbl, prop)
`define DMVP_ASSERT_IMP(lbl, ante, cons)
`define DMVP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/dmvp_pkg.sv
// ----------------------------------------------------------------------------
// Dual motor voltage to PWM - shared package
// Widths, register indexes, reset values and the per-side decision record.
// ----------------------------------------------------------------------------
`default_nettype none

package dmvp_pkg;

	localparam int CMD_W  = 16;
	localparam int MV_W   = 15;
	localparam int DUTY_W = 16;
	localparam int COMP_W = 18;   // compensated command, never wraps
	localparam int PROD_W = DUTY_W + MV_W;

	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

	localparam logic [MV_W-1:0]   DEADBAND_RST = 15'd0;
	localparam logic [MV_W-1:0]   BIAS_RST     = 15'd0;
	localparam logic [MV_W-1:0]   SAT_RST      = 15'd12000;
	localparam logic [DUTY_W-1:0] PERIOD_RST   = 16'd7000;

	typedef enum logic [2:0] {
		REG_DEADBAND     = 3'd0,
		REG_RIGHT_BIAS   = 3'd1,
		REG_SATURATION   = 3'd2,
		REG_LEFT_PERIOD  = 3'd3,
		REG_RIGHT_PERIOD = 3'd4
	} cfg_reg_t;

	// outcome of compensation and range test for one motor
	typedef struct packed {
		logic            drive;   // duty from the divider
		logic            rev;
		logic            clear;   // dead zone at a final point
		logic [MV_W-1:0] mag;
	} side_dec_t;

endpackage

`default_nettype wire

### hdl/dual_motor_voltage_to_pwm_core.sv
// ----------------------------------------------------------------------------
// Dual motor voltage to PWM core
// Converts left/right millivolt commands into PWM duty counts and directions.
// ----------------------------------------------------------------------------
// Usage:
//   One command beat on s_* (two signed commands, battery reading, final-point
//   flag in s_tuser) gives one result beat on m_* (both duties, both
//   directions, battery fault). s_tready is high only while the core is idle.
//   Each driving side runs period*magnitude/battery on one shared unit:
//   a registered multiply, one overflow check, then sixteen divide steps, one
//   quotient bit per cycle. A side in the dead zone skips the unit.
//   A saturated quotient skips its sixteen divide steps. m_tvalid and
//   s_tready rise together when a result is pushed, and no new command is
//   taken until the last one has been pushed.
//   A finished result sits in an output register; if the receiver stalls,
//   the next command may be taken, but its result waits until the register
//   frees. Configuration writes via cfg_we/cfg_addr/cfg_wdata while idle.
//   Reset clears held duties and directions, restores register defaults and
//   leaves no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_motor_voltage_to_pwm_core_defines.svh"

module dual_motor_voltage_to_pwm_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// left_cmd_mv[15:0], right_cmd_mv[31:16], battery_mv[47:32]
	input  wire logic [47:0] s_tdata,
	// final_point[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// left_duty[15:0], left_reverse[16], right_duty[32:17], right_reverse[33],
	// battery_fault[34], zero[39:35]
	output logic [39:0]      m_tdata
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LSTART = 6'b000010,
		S_LWAIT  = 6'b000100,
		S_RSTART = 6'b001000,
		S_RWAIT  = 6'b010000,
		S_PUSH   = 6'b100000
	} seq_state_t;

	seq_state_t state_q;

	logic        [dmvp_pkg::MV_W-1:0]   deadband_q;
	logic signed [dmvp_pkg::MV_W-1:0]   bias_q;
	logic        [dmvp_pkg::MV_W-1:0]   sat_q;
	logic        [dmvp_pkg::DUTY_W-1:0] left_period_q;
	logic        [dmvp_pkg::DUTY_W-1:0] right_period_q;

	logic signed [dmvp_pkg::CMD_W-1:0]  lcmd_q;
	logic signed [dmvp_pkg::CMD_W-1:0]  rcmd_q;
	logic        [dmvp_pkg::DUTY_W-1:0] bat_q;
	logic                               fin_q;

	logic [dmvp_pkg::DUTY_W-1:0] left_duty_q;
	logic                        left_dir_q;
	logic [dmvp_pkg::DUTY_W-1:0] right_duty_q;
	logic                        right_dir_q;
	logic [dmvp_pkg::DUTY_W-1:0] lq_q;
	logic [dmvp_pkg::DUTY_W-1:0] rq_q;

	logic        m_valid_q;
	logic [34:0] out_q;

	dmvp_pkg::side_dec_t l_dec;
	dmvp_pkg::side_dec_t r_dec;

	logic                        div_start;
	logic                        div_done;
	logic [dmvp_pkg::DUTY_W-1:0] div_quot;
	logic [dmvp_pkg::DUTY_W-1:0] div_period;
	logic [dmvp_pkg::MV_W-1:0]   div_mag;
	logic                        push;

	logic [dmvp_pkg::DUTY_W-1:0] l_duty_nx;
	logic                        l_dir_nx;
	logic [dmvp_pkg::DUTY_W-1:0] r_duty_nx;
	logic                        r_dir_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q     <= dmvp_pkg::DEADBAND_RST;
			bias_q         <= dmvp_pkg::BIAS_RST;
			sat_q          <= dmvp_pkg::SAT_RST;
			left_period_q  <= dmvp_pkg::PERIOD_RST;
			right_period_q <= dmvp_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			case (dmvp_pkg::cfg_reg_t'(cfg_addr))
				dmvp_pkg::REG_DEADBAND:     deadband_q     <= cfg_wdata[dmvp_pkg::MV_W-1:0];
				dmvp_pkg::REG_RIGHT_BIAS:   bias_q         <= cfg_wdata[dmvp_pkg::MV_W-1:0];
				dmvp_pkg::REG_SATURATION:   sat_q          <= cfg_wdata[dmvp_pkg::MV_W-1:0];
				dmvp_pkg::REG_LEFT_PERIOD:  left_period_q  <= cfg_wdata;
				dmvp_pkg::REG_RIGHT_PERIOD: right_period_q <= cfg_wdata;
				default: begin
					deadband_q <= deadband_q;
				end
			endcase
		end
	end

	dmvp_side u_left (
		.cmd         (lcmd_q),
		.deadband    (deadband_q),
		.bias        ('0),
		.saturation  (sat_q),
		.final_point (fin_q),
		.dec         (l_dec)
	);

	dmvp_side u_right (
		.cmd         (rcmd_q),
		.deadband    (deadband_q),
		.bias        (bias_q),
		.saturation  (sat_q),
		.final_point (fin_q),
		.dec         (r_dec)
	);

	assign div_period = (state_q == S_RSTART) ? right_period_q : left_period_q;
	assign div_mag    = (state_q == S_RSTART) ? r_dec.mag : l_dec.mag;
	assign div_start  = ((state_q == S_LSTART) && l_dec.drive) ||
	                    ((state_q == S_RSTART) && r_dec.drive);

	dmvp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.period  (div_period),
		.mag     (div_mag),
		.battery (bat_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign s_tready = (state_q == S_IDLE);
	assign push     = (state_q == S_PUSH) && (!m_valid_q || m_tready);

	// a dead-zone side clears at a final point, otherwise holds
	always_comb begin
		l_duty_nx = l_dec.drive ? lq_q : (l_dec.clear ? '0 : left_duty_q);
		l_dir_nx  = l_dec.drive ? l_dec.rev : left_dir_q;
		r_duty_nx = r_dec.drive ? rq_q : (r_dec.clear ? '0 : right_duty_q);
		r_dir_nx  = r_dec.drive ? r_dec.rev : right_dir_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			left_duty_q  <= '0;
			left_dir_q   <= 1'b0;
			right_duty_q <= '0;
			right_dir_q  <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_LSTART;
					end
				end
				S_LSTART: begin
					state_q <= l_dec.drive ? S_LWAIT : S_RSTART;
				end
				S_LWAIT: begin
					if (div_done) begin
						state_q <= S_RSTART;
					end
				end
				S_RSTART: begin
					state_q <= r_dec.drive ? S_RWAIT : S_PUSH;
				end
				S_RWAIT: begin
					if (div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push) begin
						left_duty_q  <= l_duty_nx;
						left_dir_q   <= l_dir_nx;
						right_duty_q <= r_duty_nx;
						right_dir_q  <= r_dir_nx;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: input capture, quotients, output beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			lcmd_q <= s_tdata[15:0];
			rcmd_q <= s_tdata[31:16];
			bat_q  <= s_tdata[47:32];
			fin_q  <= s_tuser;
		end
		if ((state_q == S_LWAIT) && div_done) begin
			lq_q <= div_quot;
		end
		if ((state_q == S_RWAIT) && div_done) begin
			rq_q <= div_quot;
		end
		if (push) begin
			out_q <= {(bat_q == '0), r_dir_nx, r_duty_nx, l_dir_nx, l_duty_nx};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b00000, out_q};

	`DMVP_ASSERT_NEXT(a_accept_starts_left, s_tvalid && s_tready, state_q == S_LSTART)
	`DMVP_ASSERT_IMP(a_done_only_waiting, div_done, state_q == S_LWAIT || state_q == S_RWAIT)
	`DMVP_ASSERT_NEXT(a_push_shows_beat, push, m_tvalid && state_q == S_IDLE)

endmodule

`default_nettype wire

### hdl/dmvp_side.sv
// ----------------------------------------------------------------------------
// Dual motor voltage to PWM - side decision
// Dead-zone compensation of one command and choice of direction and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module dmvp_side (
	input  wire logic signed [dmvp_pkg::CMD_W-1:0] cmd,
	input  wire logic        [dmvp_pkg::MV_W-1:0]  deadband,
	input  wire logic signed [dmvp_pkg::MV_W-1:0]  bias,
	input  wire logic        [dmvp_pkg::MV_W-1:0]  saturation,
	input  wire logic                              final_point,
	output dmvp_pkg::side_dec_t                    dec
);

	logic signed [dmvp_pkg::COMP_W-1:0] cmd_x;
	logic signed [dmvp_pkg::COMP_W-1:0] dz_x;
	logic signed [dmvp_pkg::COMP_W-1:0] bias_x;
	logic signed [dmvp_pkg::COMP_W-1:0] sat_x;
	logic signed [dmvp_pkg::COMP_W-1:0] v;
	logic signed [dmvp_pkg::COMP_W-1:0] v_neg;

	assign cmd_x  = {{(dmvp_pkg::COMP_W - dmvp_pkg::CMD_W){cmd[dmvp_pkg::CMD_W-1]}}, cmd};
	assign dz_x   = {{(dmvp_pkg::COMP_W - dmvp_pkg::MV_W){1'b0}}, deadband};
	assign bias_x = {{(dmvp_pkg::COMP_W - dmvp_pkg::MV_W){bias[dmvp_pkg::MV_W-1]}}, bias};
	assign sat_x  = {{(dmvp_pkg::COMP_W - dmvp_pkg::MV_W){1'b0}}, saturation};

	always_comb begin
		if (cmd > 0) begin
			v = cmd_x + dz_x + bias_x;
		end else if (cmd < 0) begin
			v = cmd_x - dz_x + bias_x;
		end else begin
			v = '0;
		end
	end

	assign v_neg = -v;

	always_comb begin
		dec = '0;
		if (v <= -sat_x) begin
			dec.drive = 1'b1;
			dec.rev   = 1'b1;
			dec.mag   = saturation;
		end else if (v >= sat_x) begin
			dec.drive = 1'b1;
			dec.mag   = saturation;
		end else if (v < -dz_x) begin
			// |v| is below saturation here, so it fits the magnitude field
			dec.drive = 1'b1;
			dec.rev   = 1'b1;
			dec.mag   = v_neg[dmvp_pkg::MV_W-1:0];
		end else if (v > dz_x) begin
			dec.drive = 1'b1;
			dec.mag   = v[dmvp_pkg::MV_W-1:0];
		end else begin
			dec.clear = final_point;
		end
	end

endmodule

`default_nettype wire

### hdl/dmvp_div.sv
// ----------------------------------------------------------------------------
// Dual motor voltage to PWM - shared scaling unit
// Registered multiply, overflow test, then a 16-step restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_motor_voltage_to_pwm_core_defines.svh"

module dmvp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dmvp_pkg::DUTY_W-1:0]   period,
	input  wire logic [dmvp_pkg::MV_W-1:0]     mag,
	input  wire logic [dmvp_pkg::DUTY_W-1:0]   battery,
	output logic                               done,
	output logic [dmvp_pkg::DUTY_W-1:0]        quot
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_CHK  = 3'b010,
		D_RUN  = 3'b100
	} div_state_t;

	localparam logic [3:0] LAST_STEP = 4'(dmvp_pkg::DUTY_W - 1);

	div_state_t                            state_q;
	logic [dmvp_pkg::PROD_W-1:0]           prod_q;
	logic [dmvp_pkg::DUTY_W-1:0]           bat_q;
	logic [dmvp_pkg::DUTY_W-1:0]           rem_q;
	logic [dmvp_pkg::DUTY_W-1:0]           lo_q;
	logic [3:0]                            cnt_q;
	logic                                  done_q;

	logic [dmvp_pkg::DUTY_W:0]             trial;
	logic [dmvp_pkg::DUTY_W+1:0]           diff;
	logic                                  ge;
	logic [dmvp_pkg::DUTY_W-1:0]           hi_x;

	assign trial = {rem_q, lo_q[dmvp_pkg::DUTY_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, bat_q};
	assign ge    = ~diff[dmvp_pkg::DUTY_W+1];
	assign hi_x  = {1'b0, prod_q[dmvp_pkg::PROD_W-1:dmvp_pkg::DUTY_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					if (hi_x >= bat_q) begin
						// quotient would not fit (or divisor is zero): saturate
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == LAST_STEP) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					prod_q <= period * mag;
					bat_q  <= battery;
				end
			end
			D_CHK: begin
				if (hi_x >= bat_q) begin
					lo_q <= dmvp_pkg::DUTY_MAX;
				end else begin
					rem_q <= hi_x;
					lo_q  <= prod_q[dmvp_pkg::DUTY_W-1:0];
				end
			end
			D_RUN: begin
				// shift dividend bits out and quotient bits in
				rem_q <= ge ? diff[dmvp_pkg::DUTY_W-1:0] : trial[dmvp_pkg::DUTY_W-1:0];
				lo_q  <= {lo_q[dmvp_pkg::DUTY_W-2:0], ge};
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign done = done_q;
	assign quot = lo_q;

	`DMVP_ASSERT_IMP(a_rem_below_divisor, state_q == D_RUN, rem_q < bat_q)
	`DMVP_ASSERT_IMP(a_done_returns_idle, done_q, state_q == D_IDLE)
	`DMVP_ASSERT_NEXT(a_start_to_check, start && state_q == D_IDLE, state_q == D_CHK)

endmodule

`default_nettype wire
